@@ design/vns_pkg.sv @@
// shared widths and the sidecar type for the vector normalize and scale pipeline
package vns_pkg;

  localparam int CW     = 32;          // component width
  localparam int FB     = 16;          // fraction bits
  localparam int SQ_W   = 2 * CW;      // sum of squares width
  localparam int ROOT_W = CW;          // square root width
  localparam int SREM_W = CW + 3;      // square root partial remainder width
  localparam int QW     = FB + 1;      // unit component width, at most 1.0
  localparam int NSQ    = ROOT_W;      // one root bit per cell
  localparam int NDIV   = QW;          // one quotient bit per cell
  localparam int PROD_W = QW + CW;     // unit times target length

  // data that rides along with a transaction through the cell rows
  typedef struct packed {
    logic               vld;
    logic               zero;
    logic               tneg;
    logic [2:0]         neg;
    logic [CW-1:0]      tmag;
    logic [2:0][CW-1:0] mag;
  } side_t;

endpackage

@@ design/vns_sqrt_cell.sv @@
// one cell of the square root row: settles one root bit from two radicand bits
module vns_sqrt_cell (
  input  logic                       clk_i,
  input  logic                       rst_ni,
  input  logic                       en_i,
  input  vns_pkg::side_t             side_i,
  input  logic [vns_pkg::SQ_W-1:0]   s_i,
  input  logic [vns_pkg::ROOT_W-1:0] root_i,
  input  logic [vns_pkg::SREM_W-1:0] rem_i,
  output vns_pkg::side_t             side_o,
  output logic [vns_pkg::SQ_W-1:0]   s_o,
  output logic [vns_pkg::ROOT_W-1:0] root_o,
  output logic [vns_pkg::SREM_W-1:0] rem_o
);

  logic [vns_pkg::SREM_W-1:0] rem_sh;
  logic [vns_pkg::SREM_W-1:0] trial;
  logic                       ge;

  vns_pkg::side_t             side_q;
  logic [vns_pkg::SQ_W-1:0]   s_q;
  logic [vns_pkg::ROOT_W-1:0] root_q;
  logic [vns_pkg::SREM_W-1:0] rem_q;

  always_comb begin
    rem_sh = {rem_i[vns_pkg::SREM_W-3:0], s_i[vns_pkg::SQ_W-1 -: 2]};
    trial  = {1'b0, root_i, 2'b01};
    ge     = (rem_sh >= trial);
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      side_q <= '0;
    end else if (en_i) begin
      side_q <= side_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (en_i) begin
      s_q    <= {s_i[vns_pkg::SQ_W-3:0], 2'b00};
      root_q <= {root_i[vns_pkg::ROOT_W-2:0], ge};
      rem_q  <= ge ? (rem_sh - trial) : rem_sh;
    end
  end

  assign side_o = side_q;
  assign s_o    = s_q;
  assign root_o = root_q;
  assign rem_o  = rem_q;

endmodule

@@ design/vns_div_cell.sv @@
// one cell of the divider row: one quotient bit for each of the three lanes
module vns_div_cell (
  input  logic                                  clk_i,
  input  logic                                  rst_ni,
  input  logic                                  en_i,
  input  vns_pkg::side_t                        side_i,
  input  logic [vns_pkg::ROOT_W-1:0]            len_i,
  input  logic [2:0][vns_pkg::CW-1:0]           rem_i,
  input  logic [2:0][vns_pkg::QW-1:0]           num_i,
  input  logic [2:0][vns_pkg::QW-1:0]           quo_i,
  output vns_pkg::side_t                        side_o,
  output logic [vns_pkg::ROOT_W-1:0]            len_o,
  output logic [2:0][vns_pkg::CW-1:0]           rem_o,
  output logic [2:0][vns_pkg::QW-1:0]           num_o,
  output logic [2:0][vns_pkg::QW-1:0]           quo_o
);

  logic [2:0][vns_pkg::CW:0]   part;
  logic [2:0][vns_pkg::CW:0]   diff;
  logic [2:0]                  ge;
  logic [2:0][vns_pkg::CW-1:0] rem_d;
  logic [2:0][vns_pkg::QW-1:0] quo_d;

  vns_pkg::side_t              side_q;
  logic [vns_pkg::ROOT_W-1:0]  len_q;
  logic [2:0][vns_pkg::CW-1:0] rem_q;
  logic [2:0][vns_pkg::QW-1:0] num_q;
  logic [2:0][vns_pkg::QW-1:0] quo_q;

  always_comb begin
    for (int i = 0; i < 3; i++) begin
      part[i]  = {rem_i[i], num_i[i][vns_pkg::QW-1]};
      diff[i]  = part[i] - {1'b0, len_i};
      ge[i]    = (part[i] >= {1'b0, len_i});
      rem_d[i] = ge[i] ? diff[i][vns_pkg::CW-1:0] : part[i][vns_pkg::CW-1:0];
      quo_d[i] = {quo_i[i][vns_pkg::QW-2:0], ge[i]};
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      side_q <= '0;
    end else if (en_i) begin
      side_q <= side_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (en_i) begin
      len_q <= len_i;
      rem_q <= rem_d;
      quo_q <= quo_d;
      for (int i = 0; i < 3; i++) begin
        num_q[i] <= {num_i[i][vns_pkg::QW-2:0], 1'b0};
      end
    end
  end

  assign side_o = side_q;
  assign len_o  = len_q;
  assign rem_o  = rem_q;
  assign num_o  = num_q;
  assign quo_o  = quo_q;

endmodule

@@ design/vector_normalize_scale_core.sv @@
// top level: scales a 3-d q16.16 vector to a requested length
//
//  channel | valid       | stall        | payload
//  --------+-------------+--------------+-------------------------------------------
//  input   | in_valid_i  | in_stall_o   | vec_x_i, vec_y_i, vec_z_i, target_length_i
//  output  | out_valid_o | out_stall_i  | res_x_o, res_y_o, res_z_o, zero_input_o
//
// one transaction per cycle while the output is not stalled; stages are magnitude,
// squares, sum, square root row, divider row (one bit per cell each), scale, output
// reset clears the sideband and valid bits of every stage; other data is not reset
// the whole pipeline advances whenever the output register is empty or being taken,
// so a stall on the output holds every stage and raises in_stall_o in the same cycle
module vector_normalize_scale_core (
  input  logic                    clk_i,
  input  logic                    rst_ni,
  input  logic                    in_valid_i,
  output logic                    in_stall_o,
  input  logic [vns_pkg::CW-1:0]  vec_x_i,
  input  logic [vns_pkg::CW-1:0]  vec_y_i,
  input  logic [vns_pkg::CW-1:0]  vec_z_i,
  input  logic [vns_pkg::CW-1:0]  target_length_i,
  output logic                    out_valid_o,
  input  logic                    out_stall_i,
  output logic [vns_pkg::CW-1:0]  res_x_o,
  output logic [vns_pkg::CW-1:0]  res_y_o,
  output logic [vns_pkg::CW-1:0]  res_z_o,
  output logic                    zero_input_o
);

  localparam int CW = vns_pkg::CW;

  // global advance
  logic en;
  logic out_vld_q;

  assign en         = !(out_vld_q && out_stall_i);
  assign in_stall_o = !en;

  // stage 0: sign and magnitude of each component
  logic [3:0][CW-1:0] raw;
  vns_pkg::side_t     side_d;
  vns_pkg::side_t     mag_side_q;

  always_comb begin
    raw[0] = vec_x_i;
    raw[1] = vec_y_i;
    raw[2] = vec_z_i;
    raw[3] = target_length_i;
    side_d      = '0;
    side_d.vld  = in_valid_i;
    for (int i = 0; i < 3; i++) begin
      side_d.neg[i] = raw[i][CW-1];
      side_d.mag[i] = raw[i][CW-1] ? (~raw[i] + 1'b1) : raw[i];
    end
    side_d.tneg = raw[3][CW-1];
    side_d.tmag = raw[3][CW-1] ? (~raw[3] + 1'b1) : raw[3];
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      mag_side_q <= '0;
    end else if (en) begin
      mag_side_q <= side_d;
    end
  end

  // stage 1: squares
  vns_pkg::side_t                     sqr_side_q;
  logic [2:0][vns_pkg::SQ_W-1:0]      sqr_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      sqr_side_q <= '0;
    end else if (en) begin
      sqr_side_q <= mag_side_q;
    end
  end

  always_ff @(posedge clk_i) begin
    if (en) begin
      for (int i = 0; i < 3; i++) begin
        sqr_q[i] <= mag_side_q.mag[i] * mag_side_q.mag[i];
      end
    end
  end

  // stage 2: sum of squares, never above 3 * 2^(2*CW-2)
  vns_pkg::side_t             sum_side_q;
  logic [vns_pkg::SQ_W-1:0]   sum_q;
  logic [vns_pkg::SQ_W-1:0]   sum_d;
  vns_pkg::side_t             sum_side_d;

  always_comb begin
    sum_d           = sqr_q[0] + sqr_q[1] + sqr_q[2];
    sum_side_d      = sqr_side_q;
    sum_side_d.zero = (sum_d == '0);
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      sum_side_q <= '0;
    end else if (en) begin
      sum_side_q <= sum_side_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (en) begin
      sum_q <= sum_d;
    end
  end

  // square root row: floor of the root, one bit per cell
  vns_pkg::side_t             rt_side [vns_pkg::NSQ+1];
  logic [vns_pkg::SQ_W-1:0]   rt_s    [vns_pkg::NSQ+1];
  logic [vns_pkg::ROOT_W-1:0] rt_root [vns_pkg::NSQ+1];
  logic [vns_pkg::SREM_W-1:0] rt_rem  [vns_pkg::NSQ+1];

  assign rt_side[0] = sum_side_q;
  assign rt_s[0]    = sum_q;
  assign rt_root[0] = '0;
  assign rt_rem[0]  = '0;

  for (genvar k = 0; k < vns_pkg::NSQ; k++) begin : g_sqrt
    vns_sqrt_cell u_cell (
      .clk_i  (clk_i),
      .rst_ni (rst_ni),
      .en_i   (en),
      .side_i (rt_side[k]),
      .s_i    (rt_s[k]),
      .root_i (rt_root[k]),
      .rem_i  (rt_rem[k]),
      .side_o (rt_side[k+1]),
      .s_o    (rt_s[k+1]),
      .root_o (rt_root[k+1]),
      .rem_o  (rt_rem[k+1])
    );
  end

  // divider row: unit = mag * 2^FB / len; mag <= len, so the quotient fits QW bits
  // and the first partial remainder is mag >> 1
  vns_pkg::side_t              dv_side [vns_pkg::NDIV+1];
  logic [vns_pkg::ROOT_W-1:0]  dv_len  [vns_pkg::NDIV+1];
  logic [2:0][CW-1:0]          dv_rem  [vns_pkg::NDIV+1];
  logic [2:0][vns_pkg::QW-1:0] dv_num  [vns_pkg::NDIV+1];
  logic [2:0][vns_pkg::QW-1:0] dv_quo  [vns_pkg::NDIV+1];

  assign dv_side[0] = rt_side[vns_pkg::NSQ];
  assign dv_len[0]  = rt_root[vns_pkg::NSQ];
  assign dv_quo[0]  = '0;

  for (genvar i = 0; i < 3; i++) begin : g_div_init
    assign dv_rem[0][i] = {1'b0, rt_side[vns_pkg::NSQ].mag[i][CW-1:1]};
    assign dv_num[0][i] = {rt_side[vns_pkg::NSQ].mag[i][0], {vns_pkg::FB{1'b0}}};
  end

  for (genvar k = 0; k < vns_pkg::NDIV; k++) begin : g_div
    vns_div_cell u_cell (
      .clk_i  (clk_i),
      .rst_ni (rst_ni),
      .en_i   (en),
      .side_i (dv_side[k]),
      .len_i  (dv_len[k]),
      .rem_i  (dv_rem[k]),
      .num_i  (dv_num[k]),
      .quo_i  (dv_quo[k]),
      .side_o (dv_side[k+1]),
      .len_o  (dv_len[k+1]),
      .rem_o  (dv_rem[k+1]),
      .num_o  (dv_num[k+1]),
      .quo_o  (dv_quo[k+1])
    );
  end

  // scale stage: unit magnitude times target magnitude
  vns_pkg::side_t                  mul_side_q;
  logic [2:0][vns_pkg::PROD_W-1:0] prod_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      mul_side_q <= '0;
    end else if (en) begin
      mul_side_q <= dv_side[vns_pkg::NDIV];
    end
  end

  always_ff @(posedge clk_i) begin
    if (en) begin
      for (int i = 0; i < 3; i++) begin
        prod_q[i] <= dv_quo[vns_pkg::NDIV][i] * dv_side[vns_pkg::NDIV].tmag;
      end
    end
  end

  // output stage: drop the fraction, restore the sign, saturate the one overflow case
  logic [2:0][CW:0]   res_mag;
  logic [2:0][CW-1:0] res_d;
  logic [2:0][CW-1:0] res_q;
  logic               zero_q;

  always_comb begin
    for (int i = 0; i < 3; i++) begin
      res_mag[i] = prod_q[i][vns_pkg::PROD_W-1:vns_pkg::FB];
      if (mul_side_q.zero) begin
        res_d[i] = '0;
      end else if ((mul_side_q.neg[i] != mul_side_q.tneg) && (res_mag[i] != '0)) begin
        res_d[i] = ~res_mag[i][CW-1:0] + 1'b1;
      end else if (res_mag[i] > {2'b00, {(CW-1){1'b1}}}) begin
        res_d[i] = {1'b0, {(CW-1){1'b1}}};
      end else begin
        res_d[i] = res_mag[i][CW-1:0];
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_vld_q <= 1'b0;
    end else if (en) begin
      out_vld_q <= mul_side_q.vld;
    end
  end

  always_ff @(posedge clk_i) begin
    if (en) begin
      res_q  <= res_d;
      zero_q <= mul_side_q.zero;
    end
  end

  assign out_valid_o  = out_vld_q;
  assign res_x_o      = res_q[0];
  assign res_y_o      = res_q[1];
  assign res_z_o      = res_q[2];
  assign zero_input_o = zero_q;

endmodule

@@ sim/vector_normalize_scale_core_test.sv @@
// testbench for the vector normalize and scale core: directed table then random vectors
module vector_normalize_scale_core_test;
  timeunit 1ns;
  timeprecision 1ps;

  localparam int CW        = vns_pkg::CW;
  localparam int FB        = vns_pkg::FB;
  localparam int QW        = vns_pkg::QW;
  localparam int LATENCY   = 3 + CW + QW + 2;
  localparam int WDOG_MAX  = 20000;
  localparam int N_RANDOM  = 1630;
  localparam logic [CW-1:0] ONE  = 32'h0001_0000;
  localparam logic [CW-1:0] MAXP = 32'h7fff_ffff;
  localparam logic [CW-1:0] MAXN = 32'h8000_0000;

  // one result transaction
  typedef struct packed {
    logic [CW-1:0] x;
    logic [CW-1:0] y;
    logic [CW-1:0] z;
    logic          zero;
  } scaled_t;

  // one row of the directed table; has_lit marks a typed-in expectation
  typedef struct {
    logic [CW-1:0] x, y, z, t;
    bit            has_lit;
    scaled_t       lit;
  } vec_row_t;

  logic clk_i = 1'b0;
  logic rst_ni = 1'b0;
  logic in_valid_i = 1'b0;
  logic in_stall_o;
  logic [CW-1:0] vec_x_i = '0, vec_y_i = '0, vec_z_i = '0, target_length_i = '0;
  logic out_valid_o;
  logic out_stall_i = 1'b0;
  logic [CW-1:0] res_x_o, res_y_o, res_z_o;
  logic zero_input_o;

  scaled_t scaled_q[$];
  int      err_cnt = 0;
  int      idle_cycles = 0;

  always #4 clk_i = ~clk_i;

  vector_normalize_scale_core DUT (.*);

  // floor square root of a 96-bit sum of squares
  function automatic logic [63:0] isqrt96(logic [95:0] s);
    logic [63:0] r, c;
    r = '0;
    for (int b = 48; b >= 0; b--) begin
      c = r | (64'd1 << b);
      if ({64'd0, c} * {64'd0, c} <= {32'd0, s}) r = c;
    end
    return r;
  endfunction

  // expected scaled vector for one input transaction
  function automatic scaled_t scale_vector(logic [CW-1:0] x, logic [CW-1:0] y,
                                           logic [CW-1:0] z, logic [CW-1:0] t);
    logic [CW-1:0] comp[3], mag[3], tmag;
    logic          neg[3], tneg, rneg;
    logic [95:0]   sum;
    logic [63:0]   len, unit;
    logic [127:0]  res;
    logic [CW-1:0] outc[3];
    scaled_t       r;
    comp[0] = x; comp[1] = y; comp[2] = z;
    sum = '0;
    for (int i = 0; i < 3; i++) begin
      neg[i] = comp[i][CW-1];
      mag[i] = neg[i] ? -comp[i] : comp[i];
      sum += 96'(mag[i]) * 96'(mag[i]);
    end
    tneg = t[CW-1];
    tmag = tneg ? -t : t;
    if (sum == 0) begin
      r = '{x: x, y: y, z: z, zero: 1'b1};
      return r;
    end
    len = isqrt96(sum);
    for (int i = 0; i < 3; i++) begin
      unit = (64'(mag[i]) << FB) / len;
      res  = (128'(unit) * 128'(tmag)) >> FB;
      rneg = (neg[i] != tneg) && res != 0;
      if (rneg) outc[i] = -res[CW-1:0];
      else if (res > 128'(MAXP)) outc[i] = MAXP;   // only -1.0 times most negative length
      else outc[i] = res[CW-1:0];
    end
    r = '{x: outc[0], y: outc[1], z: outc[2], zero: 1'b0};
    return r;
  endfunction

  // mostly short gaps, now and then a long one, often none
  function automatic int gap_len();
    int p;
    p = $urandom_range(99);
    if (p < 50) return 0;
    if (p < 93) return $urandom_range(1, 3);
    return $urandom_range(10, 60);
  endfunction

  // random component: mixes extremes, small values, unit-scale values and full range
  function automatic logic [CW-1:0] rand_comp();
    case ($urandom_range(7))
      0: return MAXN;
      1: return MAXP;
      2: return 32'($signed($urandom_range(0, 64)) - 32);
      3: return 32'($signed($urandom_range(0, 32'h40000)) - 32'h20000);
      4: return '0;
      default: return $urandom;
    endcase
  endfunction

  // drive one transaction and hold it until accepted
  task automatic send_vector(logic [CW-1:0] x, logic [CW-1:0] y,
                             logic [CW-1:0] z, logic [CW-1:0] t, scaled_t exp_r);
    int g;
    g = gap_len();
    if (g > 0) begin
      in_valid_i <= 1'b0;
      repeat (g) @(posedge clk_i);
    end
    in_valid_i <= 1'b1;
    vec_x_i <= x; vec_y_i <= y; vec_z_i <= z; target_length_i <= t;
    scaled_q.push_back(exp_r);
    @(posedge clk_i);
    while (in_stall_o) @(posedge clk_i);
  endtask

  // output side: compare each accepted transaction field by field
  always @(posedge clk_i) begin
    scaled_t want;
    if (rst_ni && out_valid_o && !out_stall_i) begin
      if (scaled_q.size() == 0) begin
        $display("%0t: unexpected result x=%h y=%h z=%h zero=%b", $realtime,
                 res_x_o, res_y_o, res_z_o, zero_input_o);
        err_cnt++;
      end else begin
        want = scaled_q.pop_front();
        if (res_x_o !== want.x) begin
          $display("%0t: res_x expected %h actual %h", $realtime, want.x, res_x_o);
          err_cnt++;
        end
        if (res_y_o !== want.y) begin
          $display("%0t: res_y expected %h actual %h", $realtime, want.y, res_y_o);
          err_cnt++;
        end
        if (res_z_o !== want.z) begin
          $display("%0t: res_z expected %h actual %h", $realtime, want.z, res_z_o);
          err_cnt++;
        end
        if (zero_input_o !== want.zero) begin
          $display("%0t: zero_input expected %b actual %b", $realtime, want.zero,
                   zero_input_o);
          err_cnt++;
        end
      end
    end
  end

  // receiver stall in bursts: long runs free, short and occasional long stalls
  initial begin
    int n;
    forever begin
      n = gap_len();
      out_stall_i <= (n != 0);
      repeat (n == 0 ? $urandom_range(1, 20) : n) @(posedge clk_i);
    end
  end

  // watchdog: cycles with no transaction on either side
  always @(posedge clk_i) begin
    if ((in_valid_i && !in_stall_o) || (out_valid_o && !out_stall_i)) idle_cycles <= 0;
    else idle_cycles <= idle_cycles + 1;
    if (idle_cycles >= WDOG_MAX) begin
      $display("Simulation FAILED");
      $finish;
    end
  end

  initial begin
    vec_row_t dir[$];
    scaled_t  e;
    logic [CW-1:0] x, y, z, t;
    // zero vector passes through, whatever the length
    dir.push_back('{'0, '0, '0, ONE,  1'b1, '{'0, '0, '0, 1'b1}});
    dir.push_back('{'0, '0, '0, MAXN, 1'b1, '{'0, '0, '0, 1'b1}});
    // axis-aligned unit results
    dir.push_back('{ONE, '0, '0, ONE, 1'b1, '{ONE, '0, '0, 1'b0}});
    dir.push_back('{'0, -ONE, '0, ONE, 1'b1, '{'0, -ONE, '0, 1'b0}});
    dir.push_back('{'0, '0, MAXP, ONE, 1'b1, '{'0, '0, ONE, 1'b0}});
    // negative target flips direction
    dir.push_back('{MAXN, '0, '0, -ONE, 1'b1, '{ONE, '0, '0, 1'b0}});
    // saturation: -1.0 times the most negative length, then the extreme lengths without it
    dir.push_back('{MAXN, '0, '0, MAXN, 1'b1, '{MAXP, '0, '0, 1'b0}});
    dir.push_back('{'0, 32'd1, '0, MAXN, 1'b1, '{'0, MAXN, '0, 1'b0}});
    dir.push_back('{'0, '0, 32'd1, MAXP, 1'b1, '{'0, '0, MAXP, 1'b0}});
    // zero target length
    dir.push_back('{ONE, ONE, ONE, '0, 1'b1, '{'0, '0, '0, 1'b0}});
    // remaining rows go through the predictor
    dir.push_back('{MAXP, MAXP, MAXP, MAXP, 1'b0, '0});
    dir.push_back('{MAXN, MAXN, MAXN, MAXN, 1'b0, '0});
    dir.push_back('{MAXN, MAXP, 32'd1, ONE, 1'b0, '0});
    dir.push_back('{32'd1, 32'd1, 32'd1, MAXP, 1'b0, '0});
    dir.push_back('{32'hffff_ffff, 32'd1, '0, MAXN, 1'b0, '0});
    dir.push_back('{32'h0003_0000, 32'h0004_0000, '0, 32'h0005_0000, 1'b0, '0});
    dir.push_back('{32'haaaa_aaaa, 32'h5555_5555, 32'hffff_0000, 32'h0000_ffff, 1'b0, '0});
    dir.push_back('{32'h0000_ffff, 32'hffff_0001, 32'h7fff_0000, 32'h8000_0001, 1'b0, '0});

    repeat (10) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    foreach (dir[i]) begin
      e = dir[i].has_lit ? dir[i].lit
                         : scale_vector(dir[i].x, dir[i].y, dir[i].z, dir[i].t);
      send_vector(dir[i].x, dir[i].y, dir[i].z, dir[i].t, e);
    end
    for (int n = 0; n < N_RANDOM; n++) begin
      x = rand_comp(); y = rand_comp(); z = rand_comp();
      t = ($urandom_range(3) == 0) ? ONE : rand_comp();
      send_vector(x, y, z, t, scale_vector(x, y, z, t));
    end
    in_valid_i <= 1'b0;

    while (scaled_q.size() != 0) @(posedge clk_i);
    repeat (LATENCY + 10) @(posedge clk_i);
    if (err_cnt == 0) begin
      $display("Simulation PASSED");
    end else begin
      $display("Simulation FAILED");
    end
    $finish;
  end

endmodule

@@ vector_normalize_scale_core.f @@
design/vns_pkg.sv
design/vns_sqrt_cell.sv
design/vns_div_cell.sv
design/vector_normalize_scale_core.sv
sim/vector_normalize_scale_core_test.sv
